### rtl/kcce_pkg.sv
// Package for the k-means color cluster engine: sizes, request codes, payload types.
// No dependencies.
package kcce_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int COUNT_BITS   = 24;
  localparam int IDX_BITS     = $clog2(MAX_CLUSTERS);
  localparam int SUM_BITS     = 32;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_PASS  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] cluster_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [3:0] nearest_index;
    logic [7:0] center_red;
    logic [7:0] center_green;
    logic [7:0] center_blue;
    logic       centers_changed;
  } out_item_t;

endpackage

### rtl/kmeans_color_cluster_engine_top.sv
// Top level of the k-means color cluster engine.
// Uses kcce_pkg. Holds centers, sums and counts in synchronous memories.
//
// A pixel request visits each active center once through one distance unit fed by
// the center memory. An end-of-pass request walks all MAX_CLUSTERS entries, where a
// bit-serial divider forms the three channel means for each non-empty center; there
// is no extra clear, since sums and counts are zeroed as each entry is written back.
// After reset a clearing pass over all MAX_CLUSTERS entries zeroes sums and counts
// before the first request is taken. One request is in work at a time; a result
// waits in the output register while the next request is accepted.
module kmeans_color_cluster_engine_top
  import kcce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_ACCW  = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_PDIV  = 4'd6;
  localparam logic [3:0] S_PWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Memories: centers, sums (three channels per row), counts.
  logic [23:0]             center_mem [MAX_CLUSTERS];
  logic [3*SUM_BITS-1:0]   sum_mem    [MAX_CLUSTERS];
  logic [COUNT_BITS-1:0]   count_mem  [MAX_CLUSTERS];

  logic                    c_we, s_we;
  logic [IDX_BITS-1:0]     c_waddr, s_waddr, c_raddr, s_raddr;
  logic [23:0]             c_wdata, c_rdata;
  logic [3*SUM_BITS-1:0]   s_wdata, s_rdata;
  logic [COUNT_BITS-1:0]   n_wdata, n_rdata;

  always_ff @(posedge clk) begin
    if (c_we) center_mem[c_waddr] <= c_wdata;
    c_rdata <= center_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sum_mem[s_waddr]   <= s_wdata;
      count_mem[s_waddr] <= n_wdata;
    end
    s_rdata <= sum_mem[s_raddr];
    n_rdata <= count_mem[s_raddr];
  end

  logic [3:0]          state;
  logic [4:0]          active_clusters;
  in_item_t            req;
  logic [IDX_BITS:0]   ptr;
  logic [IDX_BITS:0]   n_act;
  logic                cand_valid;
  logic [IDX_BITS-1:0] cand_idx;
  logic [IDX_BITS-1:0] best;
  logic [17:0]         best_dist;
  logic [23:0]         best_color;
  logic                changed;
  logic                pend_valid;
  out_item_t           pend;
  logic [IDX_BITS-1:0] row;

  // Divider state: one quotient bit per cycle.
  logic [1:0]            chan_sel;
  logic [5:0]            bit_cnt;
  logic [SUM_BITS-1:0]   dividend;
  logic [COUNT_BITS:0]   remainder;
  logic [SUM_BITS-1:0]   quotient;
  logic [23:0]           new_color;
  logic [COUNT_BITS-1:0] divisor;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || pend_valid;

  // Clamp the active count into 1..MAX_CLUSTERS.
  always_comb begin
    if (active_clusters == 5'd0) n_act = (IDX_BITS+1)'(1);
    else if ({1'b0, active_clusters} > 6'(MAX_CLUSTERS)) n_act = (IDX_BITS+1)'(MAX_CLUSTERS);
    else n_act = (IDX_BITS+1)'(active_clusters);
  end

  // Squared distance of the candidate center.
  logic [8:0]  dr, dg, db;
  logic [17:0] sq_dist;
  always_comb begin
    dr = (c_rdata[23:16] > req.red)   ? 9'(c_rdata[23:16] - req.red)
                                      : 9'(req.red - c_rdata[23:16]);
    dg = (c_rdata[15:8] > req.green)  ? 9'(c_rdata[15:8] - req.green)
                                      : 9'(req.green - c_rdata[15:8]);
    db = (c_rdata[7:0] > req.blue)    ? 9'(c_rdata[7:0] - req.blue)
                                      : 9'(req.blue - c_rdata[7:0]);
    sq_dist = 18'(dr) * 18'(dr) + 18'(dg) * 18'(dg) + 18'(db) * 18'(db);
  end

  // Saturating accumulate.
  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                  input logic [7:0] p);
    logic [SUM_BITS:0] t;
    t = {1'b0, s} + {{(SUM_BITS-8){1'b0}}, 1'b0, p};
    sat_add = t[SUM_BITS] ? {SUM_BITS{1'b1}} : t[SUM_BITS-1:0];
  endfunction

  logic [COUNT_BITS:0] rem_shift;
  logic [SUM_BITS-1:0] cur_sum;
  logic [7:0]          mean;
  always_comb begin
    rem_shift = {remainder[COUNT_BITS-1:0], dividend[SUM_BITS-1]};
    case (chan_sel)
      2'd0:    cur_sum = s_rdata[3*SUM_BITS-1:2*SUM_BITS];
      2'd1:    cur_sum = s_rdata[2*SUM_BITS-1:SUM_BITS];
      default: cur_sum = s_rdata[SUM_BITS-1:0];
    endcase
    mean = (quotient > 32'd255) ? 8'hFF : quotient[7:0];
  end

  // Memory port control.
  always_comb begin
    c_we    = 1'b0;
    c_waddr = req.cluster_index[IDX_BITS-1:0];
    c_wdata = {req.red, req.green, req.blue};
    c_raddr = ptr[IDX_BITS-1:0];
    s_we    = 1'b0;
    s_waddr = row;
    s_wdata = '0;
    n_wdata = '0;
    s_raddr = row;
    case (state)
      S_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = ptr[IDX_BITS-1:0];
      end
      S_IDLE: begin
        if (in_valid && !in_stall && in_data.req_type == REQ_LOAD &&
            {1'b0, in_data.cluster_index} < 5'(MAX_CLUSTERS)) begin
          c_we    = 1'b1;
          c_waddr = in_data.cluster_index[IDX_BITS-1:0];
          c_wdata = {in_data.red, in_data.green, in_data.blue};
        end
      end
      S_ACC: s_raddr = best;
      S_ACCW: begin
        s_waddr = best;
        if (n_rdata != CNT_MAX) begin
          s_we    = 1'b1;
          s_wdata = {sat_add(s_rdata[3*SUM_BITS-1:2*SUM_BITS], req.red),
                     sat_add(s_rdata[2*SUM_BITS-1:SUM_BITS], req.green),
                     sat_add(s_rdata[SUM_BITS-1:0], req.blue)};
          n_wdata = n_rdata + COUNT_BITS'(1);
        end
      end
      // Keep the current row's center on the read port through the divide.
      S_PRD, S_PDIV: c_raddr = row;
      S_PWR: begin
        c_raddr = row;
        s_we    = 1'b1;
        if (n_rdata != '0) begin
          c_we    = 1'b1;
          c_waddr = row;
          c_wdata = new_color;
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      ptr             <= '0;
      active_clusters <= 5'd16;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
      cand_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) active_clusters <= cfg_data;

      // Move a finished result into the output register.
      if (pend_valid && (!out_valid || !out_stall)) begin
        out_valid  <= 1'b1;
        out_data   <= pend;
        pend_valid <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == (IDX_BITS+1)'(MAX_CLUSTERS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req <= in_data;
            case (in_data.req_type)
              REQ_PIXEL: begin
                state      <= S_SCAN;
                ptr        <= '0;
                cand_valid <= 1'b0;
                best       <= '0;
                best_dist  <= '1;
              end
              REQ_PASS: begin
                state   <= S_PRD;
                row     <= '0;
                changed <= 1'b0;
              end
              default: begin
                pend       <= '0;
                pend_valid <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Compare the center read last cycle; lowest index wins ties.
          if (cand_valid && sq_dist < best_dist) begin
            best       <= cand_idx;
            best_dist  <= sq_dist;
            best_color <= c_rdata;
          end else if (cand_valid && cand_idx == '0) begin
            best_dist  <= sq_dist;
            best_color <= c_rdata;
          end
          cand_idx   <= ptr[IDX_BITS-1:0];
          cand_valid <= ptr < n_act;
          ptr        <= ptr + 1'b1;
          if (ptr == n_act) state <= S_ACC;
        end
        S_ACC: state <= S_ACCW;
        S_ACCW: begin
          pend       <= {4'(best), best_color, 1'b0};
          pend_valid <= 1'b1;
          state      <= S_IDLE;
        end
        S_PRD: begin
          state     <= S_PDIV;
          chan_sel  <= 2'd0;
          bit_cnt   <= '0;
        end
        S_PDIV: begin
          if (n_rdata == '0) begin
            state <= S_PWR;
          end else if (bit_cnt == '0) begin
            divisor   <= n_rdata;
            dividend  <= cur_sum;
            remainder <= '0;
            quotient  <= '0;
            bit_cnt   <= 6'd1;
          end else if (bit_cnt <= 6'(SUM_BITS)) begin
            if (rem_shift >= {1'b0, divisor}) begin
              remainder <= rem_shift - {1'b0, divisor};
              quotient  <= {quotient[SUM_BITS-2:0], 1'b1};
            end else begin
              remainder <= rem_shift;
              quotient  <= {quotient[SUM_BITS-2:0], 1'b0};
            end
            dividend <= {dividend[SUM_BITS-2:0], 1'b0};
            bit_cnt  <= bit_cnt + 1'b1;
          end else begin
            new_color <= {new_color[15:0], mean};
            bit_cnt   <= '0;
            if (chan_sel == 2'd2) state <= S_PWR;
            else chan_sel <= chan_sel + 1'b1;
          end
        end
        S_PWR: begin
          if (n_rdata != '0 && new_color != c_rdata) changed <= 1'b1;
          row <= row + 1'b1;
          if (row == IDX_BITS'(MAX_CLUSTERS - 1)) state <= S_DONE;
          else state <= S_PRD;
        end
        S_DONE: begin
          pend       <= {28'd0, changed};
          pend_valid <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/kcce_checker.sv
// Port-level checker for the k-means color cluster engine, bound to the top level.
// Uses kcce_pkg.
module kcce_checker
  import kcce_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // Only end-of-pass results flag a change, never with an index.
  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.centers_changed |-> out_data.nearest_index == '0)
    else $error("change flag with index");

  // Changed flag carries no color.
  a_flag_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.centers_changed |->
      out_data.center_red == '0 && out_data.center_green == '0 &&
      out_data.center_blue == '0)
    else $error("change flag with color");

  // An accepted request stalls the input in the cycle after it is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken back to back");

endmodule

bind kmeans_color_cluster_engine_top kcce_checker u_kcce_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### tb/sv/kmeans_color_cluster_engine_top_test.sv
// Self-checking testbench for kmeans_color_cluster_engine_top: directed and random
// requests are checked field by field against a built-in predictor of the engine.
// Depends on kcce_pkg and the engine RTL.
module kmeans_color_cluster_engine_top_test;
  import kcce_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int DRAIN_CYCLES = 2000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [4:0] cfg_data;

  kmeans_color_cluster_engine_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state
  logic [23:0] center_rgb [MAX_CLUSTERS];
  logic [31:0] rgb_sums [MAX_CLUSTERS][3];
  logic [COUNT_BITS-1:0] member_cnt [MAX_CLUSTERS];
  logic [4:0] active_setting;

  in_item_t request_queue[$];
  out_item_t awaited_responses[$];
  int mismatches;
  bit idling_on;
  bit hold_go;
  int gap_left, stall_left, hold_left;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Compute the response of one request and advance the predicted state
  function automatic out_item_t cluster_response(in_item_t r);
    out_item_t o;
    int n, best, i, k;
    int unsigned bd, d, c, p, diff;
    logic [32:0] s;
    logic [31:0] m;
    logic [23:0] nc;
    logic [7:0] px [3];
    bit moved;
    o = '0;
    px[0] = r.red; px[1] = r.green; px[2] = r.blue;
    case (r.req_type)
      REQ_LOAD: center_rgb[r.cluster_index] = {r.red, r.green, r.blue};
      REQ_PIXEL: begin
        n = (active_setting == 0) ? 1 :
            (active_setting > MAX_CLUSTERS) ? MAX_CLUSTERS : active_setting;
        best = 0;
        bd = 32'hFFFF_FFFF;
        for (i = 0; i < n; i++) begin
          d = 0;
          for (k = 0; k < 3; k++) begin
            c = center_rgb[i][23 - 8*k -: 8];
            p = px[k];
            diff = (c > p) ? c - p : p - c;
            d += diff * diff;
          end
          if (d < bd) begin
            bd = d;
            best = i;
          end
        end
        // Accumulate unless the member count is saturated
        if (member_cnt[best] < COUNT_MAX) begin
          member_cnt[best]++;
          for (k = 0; k < 3; k++) begin
            s = {1'b0, rgb_sums[best][k]} + px[k];
            rgb_sums[best][k] = s[32] ? 32'hFFFF_FFFF : s[31:0];
          end
        end
        o.nearest_index = 4'(best);
        o.center_red = center_rgb[best][23:16];
        o.center_green = center_rgb[best][15:8];
        o.center_blue = center_rgb[best][7:0];
      end
      REQ_PASS: begin
        moved = 0;
        for (i = 0; i < MAX_CLUSTERS; i++) begin
          if (member_cnt[i] != 0) begin
            for (k = 0; k < 3; k++) begin
              m = rgb_sums[i][k] / member_cnt[i];
              nc[23 - 8*k -: 8] = (m > 255) ? 8'd255 : m[7:0];
            end
            if (nc != center_rgb[i]) moved = 1;
            center_rgb[i] = nc;
          end
          member_cnt[i] = '0;
          for (k = 0; k < 3; k++) rgb_sums[i][k] = '0;
        end
        o.centers_changed = moved;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Driver: predict on acceptance, then offer the next queued request
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) awaited_responses.push_back(cluster_response(in_data));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 0;
          gap_left <= gap_left - 1;
        end else if (request_queue.size() > 0) begin
          in_data <= request_queue.pop_front();
          in_valid <= 1;
          if (idling_on && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 4);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor: check accepted results and drive stall bursts and the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          out_item_t e;
          e = awaited_responses.pop_front();
          if (out_data.nearest_index !== e.nearest_index ||
              out_data.center_red !== e.center_red ||
              out_data.center_green !== e.center_green ||
              out_data.center_blue !== e.center_blue ||
              out_data.centers_changed !== e.centers_changed) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, out_data);
          end
        end
      end
      if (hold_go) begin
        hold_go = 0;
        hold_left <= 400;
        out_stall <= 1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1;
      end else if (idling_on && $urandom_range(0, 6) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  function automatic in_item_t make_req(logic [1:0] t, logic [3:0] idx,
                                        logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_item_t it;
    it.req_type = t; it.cluster_index = idx; it.red = r; it.green = g; it.blue = b;
    return it;
  endfunction

  // Request of the given kind with random index and color
  function automatic in_item_t rand_req(logic [1:0] t);
    return make_req(t, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Hold until every queued request is accepted and its result has come back
  task automatic drain();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || awaited_responses.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_active(logic [4:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 0;
    active_setting = v;
  endtask

  // Random phase: mostly pixels, with some loads, passes and unknown requests
  task automatic random_phase(int n_items);
    int i, pick;
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        request_queue.push_back(rand_req(REQ_LOAD));
      else if (pick < 12)
        request_queue.push_back(rand_req(REQ_PASS));
      else if (pick < 14)
        request_queue.push_back(rand_req(REQ_UNKNOWN));
      else
        request_queue.push_back(rand_req(REQ_PIXEL));
    end
  endtask

  initial begin
    int i;
    logic [4:0] settings [8];
    settings = '{5'd16, 5'd1, 5'd0, 5'd17, 5'd31, 5'd5, 5'd8, 5'd16};
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_data = '0;
    mismatches = 0;
    idling_on = 1;
    hold_go = 0;
    active_setting = 16;
    for (i = 0; i < MAX_CLUSTERS; i++) begin
      center_rgb[i] = '0;
      member_cnt[i] = '0;
      rgb_sums[i][0] = 0; rgb_sums[i][1] = 0; rgb_sums[i][2] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed: load every center, extremes, equal centers for a tie, all request codes
    for (i = 0; i < MAX_CLUSTERS; i++)
      request_queue.push_back(make_req(REQ_LOAD, 4'(i), 8'(i * 17), 8'(255 - i * 17),
                                       8'(i * 8)));
    request_queue.push_back(make_req(REQ_LOAD, 4'd15, 8'd255, 8'd255, 8'd255));
    request_queue.push_back(make_req(REQ_LOAD, 4'd0, 8'd0, 8'd0, 8'd0));
    request_queue.push_back(make_req(REQ_LOAD, 4'd5, 8'd0, 8'd0, 8'd0));
    request_queue.push_back(make_req(REQ_PIXEL, 4'd0, 8'd0, 8'd0, 8'd0));
    request_queue.push_back(make_req(REQ_PIXEL, 4'd15, 8'd255, 8'd255, 8'd255));
    request_queue.push_back(make_req(REQ_PIXEL, 4'd9, 8'd128, 8'd127, 8'd1));
    request_queue.push_back(make_req(REQ_UNKNOWN, 4'd15, 8'd255, 8'd255, 8'd255));
    request_queue.push_back(make_req(REQ_PASS, 4'd0, 8'd0, 8'd0, 8'd0));
    request_queue.push_back(make_req(REQ_PASS, 4'd0, 8'd0, 8'd0, 8'd0));
    drain();

    // Random phases over several register settings
    for (i = 0; i < 8; i++) begin
      write_active(settings[i]);
      if (i == 7) idling_on = 0;
      random_phase(250);
      if (i == 2) begin
        repeat (5) @(posedge clk);
        hold_go = 1;
      end
      drain();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_responses.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
